>>> rtl/bhpq_pkg.sv
// ---------------------------------------------------------------------------
// bhpq_pkg: shared types and codes of the binary heap priority queue
// Status codes, controller states and the controller/datapath command and
// status structures.
// ---------------------------------------------------------------------------
package bhpq_pkg;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   localparam logic ACTION_PUSH = 1'b0;
   localparam logic ACTION_POP  = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PUSH_WR,
      ST_UP_RD,
      ST_UP_CMP,
      ST_POP_RD,
      ST_POP_WR,
      ST_DN_RD,
      ST_DN_CMP,
      ST_TOP_RD,
      ST_DONE
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic load;       // capture request, update count
      logic push_wr;    // write new key at the end
      logic up_rd;      // read parent of position
      logic up_swap;    // write swap for sift up, move up
      logic pop_rd;     // read root and last entry
      logic pop_wr;     // write last entry at root
      logic dn_rd;      // read children of position
      logic dn_swap;    // write swap for sift down, move down
      logic top_rd;     // read root for the result
      logic done;       // present result
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic is_push;
      logic full;
      logic empty;
      logic pos_root;   // position is the root
      logic up_better;  // key beats its parent
      logic has_kid;    // position has a left child
      logic dn_better;  // best child beats the key
      logic last_pop;   // pop leaves the heap empty
   } stat_type;

endpackage

>>> rtl/bhpq_ctrl.sv
// ---------------------------------------------------------------------------
// bhpq_ctrl: sequencer of the heap
// Steps a push or a pop through write, sift and result phases.
// ---------------------------------------------------------------------------
module bhpq_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  bhpq_pkg::stat_type stat,
   output bhpq_pkg::cmd_type  cmd
);
   import bhpq_pkg::*;

   state_type state_ff, state_in;

   // hold the state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // decode next state and commands
   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.load = 1'b1;
               state_in = ST_PUSH_WR;
            end
         end
         ST_PUSH_WR: begin
            if (stat.is_push) begin
               if (stat.full) begin
                  state_in = ST_TOP_RD;
               end else begin
                  cmd.push_wr = 1'b1;
                  state_in = ST_UP_RD;
               end
            end else if (stat.empty || stat.last_pop) begin
               state_in = ST_TOP_RD;
            end else begin
               cmd.pop_rd = 1'b1;
               state_in = ST_POP_WR;
            end
         end
         ST_UP_RD: begin
            if (stat.pos_root) begin
               state_in = ST_TOP_RD;
            end else begin
               cmd.up_rd = 1'b1;
               state_in = ST_UP_CMP;
            end
         end
         ST_UP_CMP: begin
            if (stat.up_better) begin
               cmd.up_swap = 1'b1;
               state_in = ST_UP_RD;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_POP_WR: begin
            cmd.pop_wr = 1'b1;
            state_in = ST_DN_RD;
         end
         ST_DN_RD: begin
            if (stat.has_kid) begin
               cmd.dn_rd = 1'b1;
               state_in = ST_DN_CMP;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_DN_CMP: begin
            if (stat.dn_better) begin
               cmd.dn_swap = 1'b1;
               state_in = ST_DN_RD;
            end else begin
               state_in = ST_TOP_RD;
            end
         end
         ST_TOP_RD: begin
            cmd.top_rd = 1'b1;
            state_in = ST_DONE;
         end
         ST_DONE: begin
            cmd.done = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // a result strobe always closes an operation
   a_done_to_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.done |=> state_ff == ST_IDLE)
      else $error("controller did not return to idle after result");

   // requests are only taken in idle
   a_load_idle: assert property (@(posedge clock) disable iff (reset)
      cmd.load |-> !busy)
      else $error("request taken while busy");

   // a swap is only issued after its read
   a_swap_after_read: assert property (@(posedge clock) disable iff (reset)
      (cmd.up_swap || cmd.dn_swap) |-> ($past(cmd.up_rd) || $past(cmd.dn_rd)))
      else $error("swap without preceding read");

endmodule

>>> rtl/bhpq_data.sv
// ---------------------------------------------------------------------------
// bhpq_data: heap store and sift datapath
// Holds the key store, the count, the position and the moving key, and
// compares keys under the selected order.
// ---------------------------------------------------------------------------
module bhpq_data #(
   parameter int DEPTH     = 1024,
   parameter int KEY_WIDTH = 32,
   localparam int CNT_W    = $clog2(DEPTH + 1),
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  bhpq_pkg::cmd_type    cmd,
   output bhpq_pkg::stat_type   stat,
   input  logic                 order_mode,
   input  logic                 action,
   input  logic [KEY_WIDTH-1:0] new_key,
   output logic                 rsp_valid,
   output logic [KEY_WIDTH-1:0] popped_key,
   output logic [1:0]           status,
   output logic [KEY_WIDTH-1:0] top_key,
   output logic                 is_empty,
   output logic [CNT_W-1:0]     entry_count
);
   import bhpq_pkg::*;

   logic [KEY_WIDTH-1:0] mem [DEPTH];

   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 push_ff;
   logic [1:0]           status_ff;
   logic [KEY_WIDTH-1:0] key_ff;
   logic [KEY_WIDTH-1:0] popped_ff;
   logic [CNT_W-1:0]     pos_ff;
   logic [CNT_W-1:0]     other_ff;     // parent position
   logic [KEY_WIDTH-1:0] rd_a_ff;      // parent, left child or root
   logic [KEY_WIDTH-1:0] rd_b_ff;      // right child
   logic                 b_ok_ff;      // right child present
   logic [KEY_WIDTH-1:0] top_ff;
   logic                 valid_ff;

   logic [CNT_W-1:0] parent_pos, left_pos, right_pos, kid_pos;
   logic [CNT_W:0]   left_wide;
   logic             right_wins;
   logic [KEY_WIDTH-1:0] best_key;

   function automatic logic ranks_above(input logic mode,
                                        input logic [KEY_WIDTH-1:0] a,
                                        input logic [KEY_WIDTH-1:0] b);
      ranks_above = mode ? (a > b) : (a < b);
   endfunction

   assign parent_pos = (pos_ff - 1'b1) >> 1;
   assign left_wide  = {pos_ff, 1'b1};
   assign left_pos   = left_wide[CNT_W-1:0];
   assign right_pos  = left_pos + 1'b1;
   assign right_wins = b_ok_ff && ranks_above(order_mode, rd_b_ff, rd_a_ff);
   assign best_key   = right_wins ? rd_b_ff : rd_a_ff;
   assign kid_pos    = right_wins ? right_pos : left_pos;

   // count after the operation
   always_comb begin
      count_in = count_ff;
      if (cmd.load) begin
         if (action == ACTION_PUSH) begin
            if (count_ff != DEPTH[CNT_W-1:0]) count_in = count_ff + 1'b1;
         end else if (count_ff != '0) begin
            count_in = count_ff - 1'b1;
         end
      end
   end

   // hold control state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         valid_ff <= cmd.done;
      end
   end

   // capture the request and step the sift
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         push_ff   <= (action == ACTION_PUSH);
         key_ff    <= new_key;
         pos_ff    <= count_ff;
         // last pop: the root itself leaves
         if (action == ACTION_POP && count_ff == CNT_W'(1))
            popped_ff <= mem[0];
         else
            popped_ff <= '0;
         if (action == ACTION_PUSH)
            status_ff <= (count_ff == DEPTH[CNT_W-1:0]) ? STATUS_FULL : STATUS_OK;
         else
            status_ff <= (count_ff == '0) ? STATUS_EMPTY : STATUS_OK;
      end
      if (cmd.up_rd) begin
         other_ff <= parent_pos;
         rd_a_ff  <= mem[parent_pos[ADDR_W-1:0]];
      end
      if (cmd.up_swap) begin
         pos_ff <= other_ff;
      end
      if (cmd.pop_rd) begin
         rd_a_ff <= mem[0];
         key_ff  <= mem[count_ff[ADDR_W-1:0]];
         pos_ff  <= '0;
      end
      if (cmd.pop_wr) begin
         popped_ff <= rd_a_ff;
      end
      if (cmd.dn_rd) begin
         rd_a_ff <= mem[left_pos[ADDR_W-1:0]];
         rd_b_ff <= mem[right_pos[ADDR_W-1:0]];
         b_ok_ff <= right_pos < count_ff;
      end
      if (cmd.dn_swap) begin
         pos_ff <= kid_pos;
      end
      if (cmd.top_rd) begin
         top_ff <= mem[0];
      end
   end

   // write the store: two entries at once on a swap
   always_ff @(posedge clock) begin
      if (cmd.push_wr) begin
         mem[pos_ff[ADDR_W-1:0]] <= key_ff;
      end else if (cmd.pop_wr) begin
         mem[0] <= key_ff;
      end else if (cmd.up_swap) begin
         mem[pos_ff[ADDR_W-1:0]]   <= rd_a_ff;
         mem[other_ff[ADDR_W-1:0]] <= key_ff;
      end else if (cmd.dn_swap) begin
         mem[pos_ff[ADDR_W-1:0]]  <= best_key;
         mem[kid_pos[ADDR_W-1:0]] <= key_ff;
      end
   end

   assign stat.is_push   = push_ff;
   assign stat.full      = (status_ff == STATUS_FULL);
   assign stat.empty     = (status_ff == STATUS_EMPTY);
   assign stat.last_pop  = (count_ff == '0);
   assign stat.pos_root  = (pos_ff == '0);
   assign stat.up_better = ranks_above(order_mode, key_ff, rd_a_ff);
   assign stat.has_kid   = ({1'b0, left_wide} < {2'b0, count_ff});
   assign stat.dn_better = ranks_above(order_mode, best_key, key_ff);

   assign rsp_valid   = valid_ff;
   assign popped_key  = popped_ff;
   assign status      = status_ff;
   assign top_key     = (count_ff == '0) ? '0 : top_ff;
   assign is_empty    = (count_ff == '0);
   assign entry_count = count_ff;

   // count never passes the depth
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH[CNT_W-1:0])
      else $error("entry count beyond depth");

   // refused operations leave the count alone
   a_refused_hold: assert property (@(posedge clock) disable iff (reset)
      (cmd.load && ((action == ACTION_PUSH && count_ff == DEPTH[CNT_W-1:0]) ||
                    (action == ACTION_POP && count_ff == '0)))
      |=> $stable(count_ff))
      else $error("refused operation changed the count");

   // sift position stays within the held entries
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      (cmd.up_rd || cmd.dn_rd) |-> pos_ff < count_ff)
      else $error("sift position outside the heap");

endmodule

>>> rtl/binary_heap_priority_queue.sv
// ---------------------------------------------------------------------------
// binary_heap_priority_queue: min or max heap of unsigned keys
// Push and pop with sift up and down over a key store in memory.
// ---------------------------------------------------------------------------
// One request at a time: start is taken when busy is low, and the result
// appears on the rsp_ ports for one cycle with rsp_valid, which cannot be
// held off. The sift loop runs a read then a compare-and-swap for each
// level the key moves; a pop adds a root move, and a sift that stops on a
// failed compare, rather than at the root or a leaf, adds one more read
// and compare. At DEPTH 1024 the longest operation is a push climbing 10
// levels. Refused pushes and pops, and the pop of the last entry, skip the
// sift. A new request may be taken in the strobe cycle. csr_ writes set
// the order.
module binary_heap_priority_queue #(
   parameter int DEPTH     = 1024,
   parameter int KEY_WIDTH = 32
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic                               req_action,
   input  logic [KEY_WIDTH-1:0]               req_new_key,
   output logic                               rsp_valid,
   output logic [KEY_WIDTH-1:0]               rsp_popped_key,
   output logic [1:0]                         rsp_status,
   output logic [KEY_WIDTH-1:0]               rsp_top_key,
   output logic                               rsp_is_empty,
   output logic [$clog2(DEPTH+1)-1:0]         rsp_entry_count,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic                               csr_order_mode
);
   import bhpq_pkg::*;

   cmd_type  cmd;
   stat_type stat;
   logic     order_ff;

   // hold the order register
   always_ff @(posedge clock) begin
      if (reset) begin
         order_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         order_ff <= csr_order_mode;
      end
   end
   assign csr_ready = 1'b1;

   bhpq_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .stat  (stat),
      .cmd   (cmd)
   );

   bhpq_data #(
      .DEPTH     (DEPTH),
      .KEY_WIDTH (KEY_WIDTH)
   ) u_data (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .stat        (stat),
      .order_mode  (order_ff),
      .action      (req_action),
      .new_key     (req_new_key),
      .rsp_valid   (rsp_valid),
      .popped_key  (rsp_popped_key),
      .status      (rsp_status),
      .top_key     (rsp_top_key),
      .is_empty    (rsp_is_empty),
      .entry_count (rsp_entry_count)
   );

endmodule

>>> verif/testbench.sv
// ---------------------------------------------------------------------------
// testbench: self-checking bench for binary_heap_priority_queue
// Sends push and pop requests, predicts every result with a heap kept in the
// bench and compares each result field by field, across min and max order.
// ---------------------------------------------------------------------------
module testbench;
   import bhpq_pkg::*;

   localparam int DEPTH     = 1024;
   localparam int KEY_WIDTH = 32;
   localparam int CW        = $clog2(DEPTH + 1);
   localparam int SETTLE    = 40;
   localparam int LIMIT     = 1000000;

   typedef struct packed {
      logic [KEY_WIDTH-1:0] popped_key;
      logic [1:0]           status;
      logic [KEY_WIDTH-1:0] top_key;
      logic                 is_empty;
      logic [CW-1:0]        entry_count;
   } heap_result_type;

   logic                 clock;
   logic                 reset;
   logic                 start;
   logic                 busy;
   logic                 req_action;
   logic [KEY_WIDTH-1:0] req_new_key;
   logic                 rsp_valid;
   logic [KEY_WIDTH-1:0] rsp_popped_key;
   logic [1:0]           rsp_status;
   logic [KEY_WIDTH-1:0] rsp_top_key;
   logic                 rsp_is_empty;
   logic [CW-1:0]        rsp_entry_count;
   logic                 csr_valid;
   logic                 csr_ready;
   logic                 csr_order_mode;

   // bench copy of the heap
   logic [KEY_WIDTH-1:0] model_heap [DEPTH];
   int                   model_count;
   logic                 max_order;
   heap_result_type      pending_results [$];

   int  mismatches;
   int  results_seen;
   int  cycles;
   int  pushes_sent;
   int  pops_sent;
   int  refusals;
   bit  quiet;

   binary_heap_priority_queue #(.DEPTH(DEPTH), .KEY_WIDTH(KEY_WIDTH)) DUT (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_action      (req_action),
      .req_new_key     (req_new_key),
      .rsp_valid       (rsp_valid),
      .rsp_popped_key  (rsp_popped_key),
      .rsp_status      (rsp_status),
      .rsp_top_key     (rsp_top_key),
      .rsp_is_empty    (rsp_is_empty),
      .rsp_entry_count (rsp_entry_count),
      .csr_valid       (csr_valid),
      .csr_ready       (csr_ready),
      .csr_order_mode  (csr_order_mode)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // true when a must sit above b in the current order
   function automatic bit ranks_higher(logic [KEY_WIDTH-1:0] a, logic [KEY_WIDTH-1:0] b);
      return max_order ? (a > b) : (a < b);
   endfunction

   function automatic void swap_entries(int i, int j);
      logic [KEY_WIDTH-1:0] t;
      t             = model_heap[i];
      model_heap[i] = model_heap[j];
      model_heap[j] = t;
   endfunction

   // apply one request to the bench heap and queue the result it causes
   function automatic void predict_heap_op(logic action, logic [KEY_WIDTH-1:0] key);
      heap_result_type r;
      int              pos;
      int              kid;
      r = '0;
      if (action == ACTION_PUSH) begin
         if (model_count >= DEPTH) begin
            r.status = STATUS_FULL;
         end else begin
            model_heap[model_count] = key;
            pos = model_count;
            model_count++;
            while (pos > 0 && ranks_higher(model_heap[pos], model_heap[(pos - 1) / 2])) begin
               swap_entries(pos, (pos - 1) / 2);
               pos = (pos - 1) / 2;
            end
         end
      end else begin
         if (model_count == 0) begin
            r.status = STATUS_EMPTY;
         end else begin
            r.popped_key = model_heap[0];
            model_count--;
            if (model_count > 0) begin
               model_heap[0] = model_heap[model_count];
               pos = 0;
               forever begin
                  kid = 2 * pos + 1;
                  if (kid >= model_count) break;
                  if (kid + 1 < model_count && ranks_higher(model_heap[kid + 1], model_heap[kid]))
                     kid++;
                  if (!ranks_higher(model_heap[kid], model_heap[pos])) break;
                  swap_entries(pos, kid);
                  pos = kid;
               end
            end
         end
      end
      r.top_key     = (model_count > 0) ? model_heap[0] : '0;
      r.is_empty    = (model_count == 0);
      r.entry_count = model_count[CW-1:0];
      pending_results.push_back(r);
   endfunction

   // check each result against the oldest expectation
   always @(posedge clock) begin
      heap_result_type want;
      if (!reset && rsp_valid) begin
         results_seen++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected result: popped %h status %0d top %h empty %0d count %0d",
                        rsp_popped_key, rsp_status, rsp_top_key, rsp_is_empty,
                        rsp_entry_count);
         end else begin
            want = pending_results.pop_front();
            if (rsp_popped_key !== want.popped_key || rsp_status !== want.status ||
                rsp_top_key !== want.top_key || rsp_is_empty !== want.is_empty ||
                rsp_entry_count !== want.entry_count) begin
               mismatches++;
               if (mismatches <= 10) begin
                  $display("mismatch at result %0d:", results_seen);
                  $display("  expected popped %h status %0d top %h empty %0d count %0d",
                           want.popped_key, want.status, want.top_key, want.is_empty,
                           want.entry_count);
                  $display("  actual   popped %h status %0d top %h empty %0d count %0d",
                           rsp_popped_key, rsp_status, rsp_top_key, rsp_is_empty,
                           rsp_entry_count);
               end
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_results.size());
         $display("** binary_heap_priority_queue: FAILED **");
         $finish;
      end
   end

   // send one request; start stays high so back-to-back requests need no toggle
   task automatic send_request(logic action, logic [KEY_WIDTH-1:0] key);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 13)) @(posedge clock);
      end
      start       <= 1'b1;
      req_action  <= action;
      req_new_key <= key;
      do @(posedge clock); while (busy);
      predict_heap_op(action, key);
      if (action == ACTION_PUSH) pushes_sent++;
      else pops_sent++;
      if (pending_results[$].status != STATUS_OK)
         refusals++;
   endtask

   // hold off until every result is back and the block has settled
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_order(logic mode);
      drain();
      csr_valid      <= 1'b1;
      csr_order_mode <= mode;
      do @(posedge clock); while (!csr_ready);
      max_order = mode;
      csr_valid <= 1'b0;
   endtask

   task automatic test_directed;
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_PUSH, 32'hFFFF_FFFF);
      send_request(ACTION_PUSH, 32'h0000_0000);
      send_request(ACTION_PUSH, 32'h8000_0000);
      send_request(ACTION_PUSH, 32'h0000_0001);
      send_request(ACTION_PUSH, 32'h0000_0001);
      send_request(ACTION_PUSH, 32'h7FFF_FFFF);
      send_request(ACTION_POP, 32'hFFFF_FFFF);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_PUSH, 32'h1234_5678);
      send_request(ACTION_POP, 32'h0);
   endtask

   // max order, then flip back to min with entries held
   task automatic test_order_switch;
      write_order(1'b1);
      send_request(ACTION_PUSH, 32'h0000_0005);
      send_request(ACTION_PUSH, 32'hFFFF_FFFF);
      send_request(ACTION_PUSH, 32'h0000_0000);
      send_request(ACTION_PUSH, 32'h0000_0005);
      send_request(ACTION_POP, 32'h0);
      write_order(1'b0);
      send_request(ACTION_PUSH, 32'h0000_0003);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
      send_request(ACTION_POP, 32'h0);
   endtask

   // fill to capacity, push into a full heap, then pop a deep stretch back out
   task automatic test_fill;
      int i;
      write_order(logic'($urandom_range(0, 1)));
      while (model_count < DEPTH) send_request(ACTION_PUSH, $urandom());
      send_request(ACTION_PUSH, $urandom());
      send_request(ACTION_PUSH, 32'hFFFF_FFFF);
      for (i = 0; i < 150; i++) send_request(ACTION_POP, $urandom());
   endtask

   function automatic logic [KEY_WIDTH-1:0] pick_key;
      case ($urandom_range(0, 5))
         0:       return 32'h0;
         1:       return 32'hFFFF_FFFF;
         2, 3:    return $urandom_range(0, 15);
         default: return $urandom();
      endcase
   endfunction

   // random mixes in phases, order rewritten between phases with entries held
   task automatic test_random;
      int phase;
      int i;
      int push_weight;
      for (phase = 0; phase < 8; phase++) begin
         write_order(logic'($urandom_range(0, 1)));
         push_weight = $urandom_range(3, 8);
         for (i = 0; i < 40; i++) begin
            if ($urandom_range(0, 9) < push_weight)
               send_request(ACTION_PUSH, pick_key());
            else
               send_request(ACTION_POP, $urandom());
         end
      end
   endtask

   // back-to-back requests with no idling
   task automatic test_back_to_back;
      int i;
      quiet = 1'b1;
      for (i = 0; i < 100; i++)
         send_request(logic'($urandom_range(0, 2) == 0), pick_key());
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_action     <= ACTION_PUSH;
      req_new_key    <= '0;
      csr_valid      <= 1'b0;
      csr_order_mode <= 1'b0;
      model_count = 0;
      max_order   = 1'b0;
      mismatches  = 0;
      results_seen = 0;
      cycles      = 0;
      pushes_sent = 0;
      pops_sent   = 0;
      refusals    = 0;
      quiet       = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_order_switch();
      test_fill();
      test_random();
      test_back_to_back();

      drain();
      $display("covered %0d pushes and %0d pops (%0d refused) over min and max order,",
               pushes_sent, pops_sent, refusals);
      $display("including a full heap, an empty heap and order flips; %0d results checked",
               results_seen);
      if (mismatches == 0 && pending_results.size() == 0) begin
         $display("** binary_heap_priority_queue: PASSED **");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("** binary_heap_priority_queue: FAILED **");
      end
      $finish;
   end

endmodule
